@@ src/qspc_pkg.sv @@
// qspc_pkg: shared types, constants and helpers for the quadrature speed pi controller
// depends on nothing

package qspc_pkg;

	localparam int COUNT_WIDTH_DEF    = 16;
	localparam int PWM_FULL_SCALE_DEF = 1024;
	localparam int DIGIT_W            = 8;
	localparam int ACC_W              = 72;

	localparam logic [2:0] REG_SPEED_REF = 3'd0;
	localparam logic [2:0] REG_KP        = 3'd1;
	localparam logic [2:0] REG_KI        = 3'd2;
	localparam logic [2:0] REG_SCALE     = 3'd3;
	localparam logic [2:0] REG_PERIOD    = 3'd4;
	localparam logic [2:0] REG_ILIM      = 3'd5;
	localparam logic [2:0] REG_OLIM      = 3'd6;

	localparam logic REQ_HALL = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAS,
		ST_MEAS_W,
		ST_INTEG,
		ST_INTEG_W,
		ST_PROP,
		ST_PROP_W,
		ST_CTLI,
		ST_CTLI_W,
		ST_PWM,
		ST_OUT
	} state_t;

	// start request to the serial multiplier
	typedef struct packed {
		logic              start;
		logic              accum;
		logic signed [39:0] mcand;
		logic [23:0]       mplier;
	} mul_req_t;

	typedef struct packed {
		logic                   busy;
		logic                   done;
		logic signed [ACC_W-1:0] prod;
	} mul_rsp_t;

	function automatic logic signed [ACC_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = -ACC_W'(64'sd2147483648);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// floor((x + 2^15) / 2^16), arithmetic shift is floor
	function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] y;
		y = x + ACC_W'(32768);
		return y >>> 16;
	endfunction

endpackage

@@ src/qspc_stream_if.sv @@
// qspc_stream_if: valid/ready channel used for requests and results
// depends on nothing

interface qspc_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/qspc_serial_mul.sv @@
// qspc_serial_mul: digit-serial signed by unsigned multiplier, one 8-bit digit a cycle
// depends on qspc_pkg

module qspc_serial_mul
	import qspc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int NDIG = 24 / DIGIT_W;

	logic [1:0]               cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  mc_q;
	logic [23:0]              mp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 2'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	// shift multiplier right one digit, multiplicand left one digit
	always_ff @(posedge clk) begin
		if (req.start) begin
			mc_q <= ACC_W'(req.mcand);
			mp_q <= req.mplier;
			if (!req.accum) acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + mc_q * $signed({1'b0, mp_q[DIGIT_W-1:0]});
			mc_q  <= mc_q <<< DIGIT_W;
			mp_q  <= mp_q >> DIGIT_W;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start |=> busy_q || done_q) else $error("lost work");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");

endmodule

@@ src/quadrature_speed_pi_controller_unit.sv @@
// quadrature speed pi controller top level: hall decode, count, sequencer, output register
// depends on qspc_pkg, qspc_stream_if, qspc_serial_mul
//
// A hall sample item (req_type 0) updates the signed, saturating
// transition count; the first one after reset only seeds the phase. A tick
// item (req_type 1) runs four products through one shared 8-bit
// digit-serial multiplier (count*scale, period*error, kp*error,
// ki*integral). Each product has a start state, three digit steps and a
// finish step; then come the pwm scaling state and the output register
// load. An item of either kind is accepted only while the sequencer is
// idle and the output register is empty or being emptied in that cycle, so
// a result that waits for the receiver holds off every new item.

module quadrature_speed_pi_controller_unit
	import qspc_pkg::*;
#(
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
	parameter int PWM_FULL_SCALE = PWM_FULL_SCALE_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	qspc_stream_if.sink   req,
	qspc_stream_if.source rsp
);

	// configuration registers
	logic signed [31:0] speed_ref_q;
	logic [23:0]        kp_q, ki_q, scale_q;
	logic [15:0]        period_q, olim_q;
	logic [30:0]        ilim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_ref_q <= 32'sd1638400;
			kp_q        <= 24'd524;
			ki_q        <= 24'd1311;
			scale_q     <= 24'd68266;
			period_q    <= 16'd655;
			ilim_q      <= 31'd3276800;
			olim_q      <= 16'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_REF: speed_ref_q <= cfg_data;
				REG_KP:        kp_q        <= cfg_data[23:0];
				REG_KI:        ki_q        <= cfg_data[23:0];
				REG_SCALE:     scale_q     <= cfg_data[23:0];
				REG_PERIOD:    period_q    <= cfg_data[15:0];
				REG_ILIM:      ilim_q      <= cfg_data[30:0];
				REG_OLIM:      olim_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic req_type, hall_a, hall_b;
	assign req_type = req.data[2];
	assign hall_a   = req.data[1];
	assign hall_b   = req.data[0];

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   seeded_q;
	logic [1:0] prev_q;
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic signed [31:0] integ_q;
	logic signed [31:0] meas_q, err_q, ivalue_q, ctl_q;
	logic signed [ACC_W-1:0] pacc_q;
	logic signed [COUNT_WIDTH-1:0] cnt_used_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;

	qspc_serial_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// accept only while idle and the output register is free or emptying
	logic accept;
	assign req.ready = (state_q == ST_IDLE) && !(out_valid_q && !rsp.ready);
	assign accept    = req.valid && req.ready;

	// hall decode
	logic [1:0] phase;
	logic       fwd;
	assign phase = {hall_a, hall_a ^ hall_b};
	always_comb begin
		if (phase == 2'd0)      fwd = (prev_q == 2'd3);
		else if (phase == 2'd3) fwd = (prev_q != 2'd0);
		else                    fwd = (phase > prev_q);
	end

	localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	// working values of the tick
	logic signed [ACC_W-1:0] meas_w, err_w, integ_w, ctl_w, ilim_w, olim_w;
	assign meas_w  = sat32(mrsp.prod);
	assign err_w   = sat32(ACC_W'(speed_ref_q) - ACC_W'(meas_q));
	assign ilim_w  = ACC_W'({1'b0, ilim_q});
	assign olim_w  = (olim_q > 16'd32768) ? ACC_W'(32768) : ACC_W'({1'b0, olim_q});
	always_comb begin
		integ_w = ACC_W'(integ_q) + rnd16(mrsp.prod);
		if (integ_w > ilim_w) integ_w = ilim_w;
		if (integ_w < -ilim_w) integ_w = -ilim_w;
		ctl_w = rnd16(mrsp.prod);
		if (ctl_w > olim_w) ctl_w = olim_w;
		if (ctl_w < -olim_w) ctl_w = -olim_w;
	end

	// sequencer
	always_comb begin
		state_d     = state_q;
		mreq.start  = 1'b0;
		mreq.accum  = 1'b0;
		mreq.mcand  = '0;
		mreq.mplier = '0;
		case (state_q)
			ST_IDLE: if (accept && req_type == REQ_TICK) state_d = ST_MEAS;
			ST_MEAS: begin
				mreq.start  = 1'b1;
				mreq.mcand  = 40'(cnt_used_q);
				mreq.mplier = scale_q;
				state_d     = ST_MEAS_W;
			end
			ST_MEAS_W: if (mrsp.done) state_d = ST_INTEG;
			ST_INTEG: begin
				// error is registered at this edge, so feed it straight in
				mreq.start  = 1'b1;
				mreq.mcand  = 40'(err_w);
				mreq.mplier = {8'd0, period_q};
				state_d     = ST_INTEG_W;
			end
			ST_INTEG_W: if (mrsp.done) state_d = ST_PROP;
			ST_PROP: begin
				mreq.start  = 1'b1;
				mreq.mcand  = 40'(err_q);
				mreq.mplier = kp_q;
				state_d     = ST_PROP_W;
			end
			ST_PROP_W: if (mrsp.done) state_d = ST_CTLI;
			ST_CTLI: begin
				mreq.start  = 1'b1;
				mreq.accum  = 1'b1;
				mreq.mcand  = 40'(ivalue_q);
				mreq.mplier = ki_q;
				state_d     = ST_CTLI_W;
			end
			ST_CTLI_W: if (mrsp.done) state_d = ST_PWM;
			ST_PWM: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// count, phase and integral state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			prev_q   <= 2'd0;
			count_q  <= '0;
			integ_q  <= '0;
		end else begin
			if (accept && req_type == REQ_HALL) begin
				seeded_q <= 1'b1;
				prev_q   <= phase;
				if (seeded_q && phase != prev_q) begin
					if (fwd && count_q != CMAX)       count_q <= count_q + COUNT_WIDTH'(1);
					else if (!fwd && count_q != CMIN) count_q <= count_q - COUNT_WIDTH'(1);
				end
			end else if (accept && req_type == REQ_TICK) begin
				count_q <= '0;
			end
			if (state_q == ST_INTEG_W && mrsp.done) integ_q <= integ_w[31:0];
		end
	end

	// tick datapath registers
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_TICK) cnt_used_q <= count_q;
		if (state_q == ST_MEAS_W && mrsp.done) meas_q <= meas_w[31:0];
		if (state_q == ST_INTEG) err_q <= err_w[31:0];
		if (state_q == ST_INTEG_W && mrsp.done) ivalue_q <= integ_w[31:0];
		if (state_q == ST_CTLI_W && mrsp.done) ctl_q <= ctl_w[31:0];
		pacc_q <= ACC_W'(PWM_FULL_SCALE) * (ACC_W'(32768) + ACC_W'(ctl_q));
	end

	// output register
	logic [10:0] pwm_w;
	logic signed [15:0] seen_w;
	assign pwm_w = 11'(pacc_q >>> 16);
	always_comb begin
		if (ACC_W'(cnt_used_q) > ACC_W'(32767))       seen_w = 16'sh7fff;
		else if (ACC_W'(cnt_used_q) < -ACC_W'(32768)) seen_w = 16'sh8000;
		else                                          seen_w = 16'(cnt_used_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == ST_OUT) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) rsp.data <= {pwm_w, meas_q, err_q, ivalue_q, seen_w};
	end

	assign rsp.valid = out_valid_q;

	// out register must be free when the sequencer drops a result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !out_valid_q || rsp.ready) else $error("result overwritten");
	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !req.ready) else $error("accept while busy");
	a_tick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_TICK |=> count_q == '0) else $error("count not cleared");

endmodule
